// ===== rtl/square_matrix_multiply_assert.svh =====
// Assertion macros for the square matrix multiply checker.
`ifndef SQUARE_MATRIX_MULTIPLY_ASSERT_SVH
`define SQUARE_MATRIX_MULTIPLY_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("square_matrix_multiply check failed");

// Consequent must hold in the cycle after the antecedent.
`define SMM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("square_matrix_multiply check failed");

`endif

// ===== rtl/smm_pkg.sv =====
// Shared types and constants for the square matrix multiply block.
package smm_pkg;

    localparam int SIZE_DEF = 16;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = 4;
    localparam int RANGE_W  = 8;

    typedef enum logic {
        MODE_LOAD    = 1'b0,
        MODE_COMPUTE = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode                     mode;
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic signed [DATA_W-1:0]  a_value;
        logic signed [DATA_W-1:0]  b_value;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]          out_row;
        logic [IDX_W-1:0]          out_col;
        logic signed [DATA_W-1:0]  product_value;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_we;
        logic capture;
        logic issue;
        logic result_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_compute;
        logic in_range;
        logic last_issue;
        logic pipe_busy;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/smm_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module smm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/smm_ctrl.sv =====
// Controller state machine that sequences loads and dot product runs.
module smm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  smm_pkg::t_dp_sts i_sts,
    output smm_pkg::t_dp_cmd o_cmd
);

    import smm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd n_cmd;

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.in_compute) begin
                        n_cmd.capture = 1'b1;
                        // An out of range compute skips the run and returns zero.
                        n_state = i_sts.in_range ? S_RUN : S_FINISH;
                    end else begin
                        n_cmd.load_we = 1'b1;
                    end
                end
            end
            S_RUN: begin
                n_cmd.issue = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    n_cmd.result_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = n_cmd;

endmodule

// ===== rtl/smm_dpath.sv =====
// Datapath: matrix stores, address generation, multiply-accumulate and result register.
module smm_dpath #(
    parameter int SIZE = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  smm_pkg::t_dp_cmd  i_cmd,
    input  smm_pkg::t_in_item i_in_data,
    input  logic              i_out_stall,
    output smm_pkg::t_dp_sts  o_sts,
    output logic              o_out_valid,
    output smm_pkg::t_out_item o_out_data
);

    import smm_pkg::*;

    localparam int DEPTH = SIZE * SIZE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW    = (SIZE > 1) ? $clog2(SIZE) : 1;

    logic [IDX_W-1:0]  r_row;
    logic [IDX_W-1:0]  r_col;
    logic [KW-1:0]     r_k;
    logic              r_rd_vld;
    logic              r_prod_vld;
    logic [DATA_W-1:0] r_prod;
    logic [DATA_W-1:0] r_acc;
    logic              r_out_valid;
    t_out_item         r_out_data;

    logic              in_range;
    logic              last_issue;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     a_raddr;
    logic [AW-1:0]     b_raddr;
    logic [DATA_W-1:0] a_rdata;
    logic [DATA_W-1:0] b_rdata;

    assign in_range = (RANGE_W'(i_in_data.row) < RANGE_W'(SIZE)) &&
                      (RANGE_W'(i_in_data.col) < RANGE_W'(SIZE));
    assign we       = i_cmd.load_we && in_range;
    assign waddr    = AW'(i_in_data.row) * AW'(SIZE) + AW'(i_in_data.col);
    assign a_raddr  = AW'(r_row) * AW'(SIZE) + AW'(r_k);
    assign b_raddr  = AW'(r_k) * AW'(SIZE) + AW'(r_col);
    assign last_issue = (r_k == KW'(SIZE - 1));

    smm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_in_data.a_value),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    smm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_in_data.b_value),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    // Payload registers; the low half of the product is the same for signed and unsigned.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_row <= i_in_data.row;
            r_col <= i_in_data.col;
        end
        r_prod <= DATA_W'(a_rdata * b_rdata);
        if (i_cmd.capture) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + r_prod;
        end
        if (i_cmd.result_load) begin
            r_out_data.out_row       <= r_row;
            r_out_data.out_col       <= r_col;
            r_out_data.product_value <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_rd_vld    <= 1'b0;
            r_prod_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.capture || (i_cmd.issue && last_issue)) begin
                r_k <= '0;
            end else if (i_cmd.issue) begin
                r_k <= r_k + 1'b1;
            end
            r_rd_vld   <= i_cmd.issue;
            r_prod_vld <= r_rd_vld;
            if (i_cmd.result_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.in_compute = (i_in_data.mode == MODE_COMPUTE);
        o_sts.in_range   = in_range;
        o_sts.last_issue = last_issue;
        o_sts.pipe_busy  = r_rd_vld || r_prod_vld;
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/square_matrix_multiply.sv =====
// Square integer matrix multiply engine: a load transfer whose row and column are
// below SIZE writes one entry of A and the same position of B together and returns
// nothing; the block is ready for the next transfer at once. A compute transfer
// returns one entry of A x B, the row-column dot product wrapped to 32 bits: SIZE
// reads of one shared multiply-accumulate unit, fed by one read port on each matrix
// RAM, pass through the registered RAM read and the registered product into the
// accumulator; the controller waits until the pipeline is empty and then loads the
// result register. A compute with a row or column of SIZE or more skips the run and
// returns zero. The input is stalled while a compute runs and opens the cycle after
// its result is loaded; an output stall while the result register is full holds the
// load back and keeps the input stalled. The result register lets the next transfer
// in while a result still waits downstream.
module square_matrix_multiply #(
    parameter int SIZE = smm_pkg::SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  smm_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output smm_pkg::t_out_item o_out_data
);

    import smm_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    smm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    smm_dpath #(
        .SIZE (SIZE)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/smm_checker.sv =====
// Port-level checker for the square matrix multiply block, with its bind.
`include "square_matrix_multiply_assert.svh"

module smm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input smm_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input smm_pkg::t_out_item o_out_data
);

    import smm_pkg::*;

    logic in_xfer;

    assign in_xfer = i_in_valid && !o_in_stall;

    // A result that is held back stays offered and unchanged.
    `SMM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `SMM_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out_data))

    // A load finishes in the cycle of its transfer.
    `SMM_ASSERT_NEXT(a_load_ready, in_xfer && (i_in_data.mode == MODE_LOAD), !o_in_stall)

    // A compute transfer always makes the block busy.
    `SMM_ASSERT_NEXT(a_compute_busy, in_xfer && (i_in_data.mode == MODE_COMPUTE), o_in_stall)

    // A new result only comes out of a running compute.
    `SMM_ASSERT_NOW(a_result_source, $rose(o_out_valid), $past(o_in_stall))

endmodule

bind square_matrix_multiply smm_checker u_smm_checker (.*);
